@@ rtl/pfa_pkg.sv @@
// Package for the page frame allocator: sizes, codes, state and the
// controller/datapath command and status structs. No dependencies.
package pfa_pkg;

	localparam int NUM_FRAMES = 4096;
	localparam int MAX_RUN    = 256;
	localparam int FRAME_W    = $clog2(NUM_FRAMES);
	localparam int LINK_W     = FRAME_W + 1;
	localparam int LEN_W      = $clog2(MAX_RUN) + 1;
	localparam int TAG_W      = 32;

	localparam logic [TAG_W-1:0]  TAG_FREE  = 32'h4652_4545;
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_FRAMES);

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_OOM    = 2'd1,
		STAT_NORUN  = 2'd2,
		STAT_BADLEN = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_FREE_WR, S_POP_RD, S_POP_WAIT,
		S_WALK, S_CHK_RD, S_CHK_EVAL, S_ADV_RD, S_ADV_WAIT,
		S_AFT_RD, S_AFT_WAIT, S_SWEEP, S_RESP
	} state_t;

	typedef enum logic [2:0] {
		RD_NONE, RD_HEAD, RD_P, RD_CHECK, RD_AFTER
	} rd_sel_t;

	typedef struct packed {
		logic    load_in;
		logic    clr_step;
		logic    free_wr;
		rd_sel_t rd_sel;
		logic    pop_commit;
		logic    walk_init;
		logic    adv;
		logic    chk_start;
		logic    chk_next;
		logic    unlink;
		logic    sweep_wr;
		logic    res_we;
		status_t res_code;
		logic    out_load;
	} pfa_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_free;
		logic bad_len;
		logic len_one;
		logic pool_empty;
		logic too_few;
		logic walk_stop;
		logic in_bounds;
		logic chk_ok;
		logic chk_last;
		logic sweep_last;
		logic out_free;
	} pfa_stat_t;

endpackage

@@ rtl/page_frame_allocator_unit.sv @@
// channel  | signals                                   | dir | notes
// in       | in_valid in_ready cmd run_length          | in  | one command word
//          | alloc_tag frame                           |     |
// out      | out_valid out_ready status frame_index    | out | one result word
//          | free_frames                               |     |
// cfg      | cfg_we cfg_wdata                          | in  | frame_limit, no wait
//
// Free and pop work on the list head. Run allocate walks the free list,
// checks each start that lies in bounds frame by frame and then sweeps
// the run; each memory has a single read port.
// After reset a clearing pass over every frame runs with in_ready low.
// A finished word waits in the output register; the engine stalls in its
// last state only if that register is still full.
// Top level: joins pfa_ctrl and pfa_dp. Uses pfa_pkg.
module page_frame_allocator_unit import pfa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [LEN_W-1:0]    run_length,
	input  logic [TAG_W-1:0]    alloc_tag,
	input  logic [FRAME_W-1:0]  frame,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [FRAME_W-1:0]  frame_index,
	output logic [LINK_W-1:0]   free_frames,
	input  logic                cfg_we,
	input  logic [LINK_W-1:0]   cfg_wdata
);

	pfa_cmd_t  ctl;
	pfa_stat_t sts;

	pfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	pfa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.run_length  (run_length),
		.alloc_tag   (alloc_tag),
		.frame       (frame),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.status      (status),
		.frame_index (frame_index),
		.free_frames (free_frames)
	);

endmodule

@@ rtl/pfa_dp.sv @@
// Datapath of the page frame allocator: tag and link memories, list head,
// free count, walk registers and the result word register. Uses pfa_pkg.
module pfa_dp import pfa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  pfa_cmd_t            ctl,
	output pfa_stat_t           sts,
	input  logic                cfg_we,
	input  logic [LINK_W-1:0]   cfg_wdata,
	input  logic                cmd,
	input  logic [LEN_W-1:0]    run_length,
	input  logic [TAG_W-1:0]    alloc_tag,
	input  logic [FRAME_W-1:0]  frame,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [1:0]          status,
	output logic [FRAME_W-1:0]  frame_index,
	output logic [LINK_W-1:0]   free_frames
);

	logic [TAG_W-1:0]  tag_mem  [NUM_FRAMES];
	logic [LINK_W-1:0] link_mem [NUM_FRAMES];

	logic              cmd_q;
	logic [LEN_W-1:0]  len_q;
	logic [TAG_W-1:0]  tag_q;
	logic [FRAME_W-1:0] frm_q;
	logic [LINK_W-1:0] head_q, count_q, limit_q, p_q, prev_q, steps_q;
	logic [LEN_W-1:0]  n_q;
	logic [FRAME_W-1:0] clr_q;
	status_t           res_code_q;
	logic [FRAME_W-1:0] res_idx_q;
	logic [TAG_W-1:0]  tag_rd_q;
	logic [LINK_W-1:0] link_rd_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [FRAME_W-1:0] frame_index_q;
	logic [LINK_W-1:0] free_frames_q;

	logic [LINK_W-1:0]  lim_eff;
	logic [LINK_W:0]    run_end;
	logic [FRAME_W-1:0] pn_addr, tag_raddr, link_raddr;
	logic               tag_we, link_we;
	logic [FRAME_W-1:0] tag_waddr, link_waddr;
	logic [TAG_W-1:0]   tag_wdata;
	logic [LINK_W-1:0]  link_wdata;

	assign lim_eff = (limit_q > LINK_W'(NUM_FRAMES)) ? LINK_W'(NUM_FRAMES) : limit_q;
	assign run_end = {1'b0, p_q} + (LINK_W+1)'(len_q);
	assign pn_addr = p_q[FRAME_W-1:0] + FRAME_W'(n_q);

	always_comb begin
		tag_raddr  = pn_addr;
		link_raddr = head_q[FRAME_W-1:0];
		case (ctl.rd_sel)
			RD_HEAD:  link_raddr = head_q[FRAME_W-1:0];
			RD_P:     link_raddr = p_q[FRAME_W-1:0];
			RD_CHECK: link_raddr = pn_addr - FRAME_W'(1);
			RD_AFTER: link_raddr = p_q[FRAME_W-1:0] + FRAME_W'(len_q) - FRAME_W'(1);
			default:  link_raddr = head_q[FRAME_W-1:0];
		endcase
	end

	// write port select, one source per cycle
	always_comb begin
		tag_we     = 1'b0;
		tag_waddr  = clr_q;
		tag_wdata  = '0;
		link_we    = 1'b0;
		link_waddr = clr_q;
		link_wdata = LINK_NULL;
		if (ctl.clr_step) begin
			tag_we  = 1'b1;
			link_we = 1'b1;
		end else if (ctl.free_wr) begin
			tag_we     = 1'b1;
			tag_waddr  = frm_q;
			tag_wdata  = TAG_FREE;
			link_we    = 1'b1;
			link_waddr = frm_q;
			link_wdata = head_q;
		end else if (ctl.pop_commit) begin
			tag_we     = 1'b1;
			tag_waddr  = head_q[FRAME_W-1:0];
			tag_wdata  = tag_q;
			link_we    = 1'b1;
			link_waddr = head_q[FRAME_W-1:0];
		end else if (ctl.unlink) begin
			link_we    = ~prev_q[FRAME_W];
			link_waddr = prev_q[FRAME_W-1:0];
			link_wdata = link_rd_q;
		end else if (ctl.sweep_wr) begin
			tag_we     = 1'b1;
			tag_waddr  = pn_addr;
			tag_wdata  = tag_q;
			link_we    = 1'b1;
			link_waddr = pn_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
		if (link_we) link_mem[link_waddr] <= link_wdata;
		tag_rd_q  <= tag_mem[tag_raddr];
		link_rd_q <= link_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= cmd;
			len_q <= run_length;
			tag_q <= alloc_tag;
			frm_q <= frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= LINK_NULL;
			count_q    <= '0;
			limit_q    <= LINK_W'(NUM_FRAMES);
			p_q        <= LINK_NULL;
			prev_q     <= LINK_NULL;
			steps_q    <= '0;
			n_q        <= '0;
			clr_q      <= '0;
			res_code_q <= STAT_OK;
			res_idx_q  <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (ctl.clr_step) clr_q <= clr_q + FRAME_W'(1);
			if (ctl.load_in) res_idx_q <= '0;
			if (ctl.res_we) res_code_q <= ctl.res_code;
			if (ctl.free_wr) begin
				head_q <= {1'b0, frm_q};
				if (count_q < LINK_W'(NUM_FRAMES)) count_q <= count_q + LINK_W'(1);
			end
			if (ctl.pop_commit) begin
				head_q    <= link_rd_q;
				count_q   <= count_q - LINK_W'(1);
				res_idx_q <= head_q[FRAME_W-1:0];
			end
			if (ctl.walk_init) begin
				p_q     <= head_q;
				prev_q  <= LINK_NULL;
				steps_q <= '0;
			end
			if (ctl.adv) begin
				prev_q  <= p_q;
				p_q     <= link_rd_q;
				steps_q <= steps_q + LINK_W'(1);
			end
			if (ctl.chk_start) n_q <= '0;
			if (ctl.chk_next || ctl.sweep_wr) n_q <= n_q + LEN_W'(1);
			if (ctl.unlink) begin
				if (prev_q[FRAME_W]) head_q <= link_rd_q;
				count_q   <= count_q - LINK_W'(len_q);
				res_idx_q <= p_q[FRAME_W-1:0];
				n_q       <= '0;
			end
		end
	end

	// result word register, parts the output side from the engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status_q      <= res_code_q;
			frame_index_q <= res_idx_q;
			free_frames_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign frame_index = frame_index_q;
	assign free_frames = free_frames_q;

	assign sts.clr_done   = (clr_q == '1);
	assign sts.is_free    = cmd_q;
	assign sts.bad_len    = (len_q == '0) || (len_q > LEN_W'(MAX_RUN));
	assign sts.len_one    = (len_q == LEN_W'(1));
	assign sts.pool_empty = (count_q == '0) || head_q[FRAME_W];
	assign sts.too_few    = (count_q < LINK_W'(len_q));
	assign sts.walk_stop  = (steps_q == LINK_W'(NUM_FRAMES)) || p_q[FRAME_W];
	assign sts.in_bounds  = (run_end < {1'b0, lim_eff});
	assign sts.chk_ok     = (tag_rd_q == TAG_FREE) &&
	                        ((n_q == '0) || (link_rd_q == p_q + LINK_W'(n_q)));
	assign sts.chk_last   = ((n_q + LEN_W'(1)) == len_q);
	assign sts.sweep_last = ((n_q + LEN_W'(1)) == len_q);
	assign sts.out_free   = ~out_valid_q | out_ready;

endmodule

@@ rtl/pfa_ctrl.sv @@
// Controller state machine of the page frame allocator: sequences the
// clearing pass, free, pop, list walk, run sweep and response. Uses pfa_pkg.
module pfa_ctrl import pfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pfa_stat_t sts,
	output pfa_cmd_t  ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:    if (sts.clr_done) state_d = S_IDLE;
			S_IDLE:     if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (sts.is_free) state_d = S_FREE_WR;
				else if (sts.bad_len) state_d = S_RESP;
				else if (sts.len_one) state_d = sts.pool_empty ? S_RESP : S_POP_RD;
				else if (sts.too_few) state_d = S_RESP;
				else state_d = S_WALK;
			end
			S_FREE_WR:  state_d = S_RESP;
			S_POP_RD:   state_d = S_POP_WAIT;
			S_POP_WAIT: state_d = S_RESP;
			S_WALK: begin
				if (sts.walk_stop) state_d = S_RESP;
				else if (sts.in_bounds) state_d = S_CHK_RD;
				else state_d = S_ADV_RD;
			end
			S_CHK_RD:   state_d = S_CHK_EVAL;
			S_CHK_EVAL: begin
				if (!sts.chk_ok) state_d = S_ADV_RD;
				else if (sts.chk_last) state_d = S_AFT_RD;
				else state_d = S_CHK_RD;
			end
			S_ADV_RD:   state_d = S_ADV_WAIT;
			S_ADV_WAIT: state_d = S_WALK;
			S_AFT_RD:   state_d = S_AFT_WAIT;
			S_AFT_WAIT: state_d = S_SWEEP;
			S_SWEEP:    if (sts.sweep_last) state_d = S_RESP;
			S_RESP:     if (sts.out_free) state_d = S_IDLE;
			default:    state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: ctl.clr_step = 1'b1;
			S_IDLE: begin
				in_ready    = 1'b1;
				ctl.load_in = in_valid;
			end
			S_DECODE: begin
				ctl.res_we = 1'b1;
				if (sts.is_free) ctl.res_code = STAT_OK;
				else if (sts.bad_len) ctl.res_code = STAT_BADLEN;
				else if (sts.len_one) ctl.res_code = sts.pool_empty ? STAT_OOM : STAT_OK;
				else if (sts.too_few) ctl.res_code = STAT_NORUN;
				else ctl.res_code = STAT_OK;
				ctl.walk_init = ~sts.is_free & ~sts.bad_len & ~sts.len_one & ~sts.too_few;
			end
			S_FREE_WR:  ctl.free_wr = 1'b1;
			S_POP_RD:   ctl.rd_sel = RD_HEAD;
			S_POP_WAIT: ctl.pop_commit = 1'b1;
			S_WALK: begin
				ctl.chk_start = ~sts.walk_stop & sts.in_bounds;
				if (sts.walk_stop) begin
					ctl.res_we   = 1'b1;
					ctl.res_code = STAT_NORUN;
				end
			end
			S_CHK_RD:   ctl.rd_sel = RD_CHECK;
			S_CHK_EVAL: ctl.chk_next = sts.chk_ok & ~sts.chk_last;
			S_ADV_RD:   ctl.rd_sel = RD_P;
			S_ADV_WAIT: ctl.adv = 1'b1;
			S_AFT_RD:   ctl.rd_sel = RD_AFTER;
			S_AFT_WAIT: ctl.unlink = 1'b1;
			S_SWEEP:    ctl.sweep_wr = 1'b1;
			S_RESP:     ctl.out_load = sts.out_free;
			default:    ctl = '0;
		endcase
	end

endmodule

@@ rtl/pfa_checker.sv @@
// Port checker for page_frame_allocator_unit, bound to the top level.
// Uses pfa_pkg.
module pfa_port_checker import pfa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [FRAME_W-1:0] frame_index,
	input logic [LINK_W-1:0]  free_frames
);

	// a held word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(frame_index) && $stable(free_frames))
		else $error("result word changed while stalled");

	// one command at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> frame_index == '0)
		else $error("frame index set on failure");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> free_frames <= LINK_W'(NUM_FRAMES))
		else $error("free count beyond table size");

endmodule

bind page_frame_allocator_unit pfa_port_checker u_pfa_port_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.frame_index (frame_index),
	.free_frames (free_frames)
);
